// ===== rtl/pbf_pkg.sv =====
`timescale 1ns / 1ps

package pbf_pkg;

    localparam int NUM_HASHES     = 5;
    localparam int SECTION_LENGTH = 16384;
    localparam int OFF_W          = $clog2(SECTION_LENGTH);
    localparam int FIFO_DEPTH     = 8;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
    localparam int PIPE_STAGES    = 5;
    localparam int STAGE_W        = $clog2(PIPE_STAGES + 1);

    localparam logic [31:0] MUR_C1     = 32'hcc9e2d51;
    localparam logic [31:0] MUR_C2     = 32'h1b873593;
    localparam logic [31:0] MUR_E      = 32'he6546b64;
    localparam logic [31:0] MUR_F1     = 32'h85ebca6b;
    localparam logic [31:0] MUR_F2     = 32'hc2b2ae35;
    localparam logic [31:0] KEY_BYTES  = 32'd4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef logic [OFF_W-1:0] offset_t;

    typedef struct packed {
        logic                         cmd;
        offset_t [NUM_HASHES-1:0]     offs;
    } pbf_op_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int r);
        rotl32 = (v << r) | (v >> (32 - r));
    endfunction

endpackage

// ===== rtl/pbf_if.sv =====
`timescale 1ns / 1ps

interface pbf_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] key;

    modport source (output valid, output command, output key, input ready);
    modport sink (input valid, input command, input key, output ready);
endinterface

interface pbf_out_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, output hit, input ready);
    modport sink (input valid, input hit, output ready);
endinterface

// ===== rtl/pbf_front.sv =====
`timescale 1ns / 1ps

module pbf_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     command,
    input  logic [31:0]              key,
    output logic                     push,
    output pbf_pkg::pbf_op_t         op,
    output logic [pbf_pkg::STAGE_W-1:0] inflight
);
    import pbf_pkg::*;

    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;
    logic [PIPE_STAGES-1:0] cmd_reg;
    logic [31:0]            s1_reg;
    logic [31:0]            s2_reg;
    logic [31:0]            s3_reg [NUM_HASHES];
    logic [31:0]            s4_reg [NUM_HASHES];
    logic [31:0]            s5_reg [NUM_HASHES];
    logic [31:0]            s2_next;
    logic [31:0]            s3_next [NUM_HASHES];
    logic [31:0]            s4_next [NUM_HASHES];
    logic [31:0]            s5_next [NUM_HASHES];

    always_comb
    begin
        logic [31:0] h;
        logic [31:0] t;
        vld_next = {vld_reg[PIPE_STAGES-2:0], accept};
        s2_next  = rotl32(s1_reg, 15) * MUR_C2;
        for (int i = 0; i < NUM_HASHES; i++)
        begin
            h = rotl32(s2_reg ^ 32'(i), 13);
            h = ((h * 32'd5) + MUR_E) ^ KEY_BYTES;
            s3_next[i] = h ^ (h >> 16);
            s4_next[i] = s3_reg[i] * MUR_F1;
            s5_next[i] = (s4_reg[i] ^ (s4_reg[i] >> 13)) * MUR_F2;
            t = s5_reg[i] ^ (s5_reg[i] >> 16);
            op.offs[i] = t[OFF_W-1:0];
        end
        op.cmd = cmd_reg[PIPE_STAGES-1];
    end

    assign push = vld_reg[PIPE_STAGES-1];

    always_comb
    begin
        inflight = '0;
        for (int i = 0; i < PIPE_STAGES; i++)
        begin
            inflight = inflight + STAGE_W'(vld_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= {cmd_reg[PIPE_STAGES-2:0], command};
        s1_reg  <= key * MUR_C1;
        s2_reg  <= s2_next;
        for (int i = 0; i < NUM_HASHES; i++)
        begin
            s3_reg[i] <= s3_next[i];
            s4_reg[i] <= s4_next[i];
            s5_reg[i] <= s5_next[i];
        end
    end

endmodule

// ===== rtl/pbf_fifo.sv =====
`timescale 1ns / 1ps

module pbf_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  pbf_pkg::pbf_op_t           wdata,
    input  logic                       pop,
    output pbf_pkg::pbf_op_t           rdata,
    output logic                       not_empty,
    output logic [pbf_pkg::FIFO_AW:0]  count
);
    import pbf_pkg::*;

    pbf_op_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wptr_reg;
    logic [FIFO_AW-1:0]  rptr_reg;
    logic [FIFO_AW:0]    count_reg;

    assign rdata     = mem_reg[rptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/pbf_back.sv =====
`timescale 1ns / 1ps

module pbf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  pbf_pkg::pbf_op_t  op,
    output logic              pop,
    output logic              res_valid,
    output logic              hit,
    input  logic              res_ready,
    output logic              clearing
);
    import pbf_pkg::*;

    logic                  clear_reg;
    offset_t               clr_idx_reg;
    logic                  res_valid_reg;
    logic [NUM_HASHES-1:0] rd_reg;
    logic                  wr_en;
    logic                  rd_en;

    assign pop = op_valid && !clear_reg &&
                 ((op.cmd == CMD_INSERT) || !res_valid_reg || res_ready);
    assign wr_en     = clear_reg || (pop && (op.cmd == CMD_INSERT));
    assign rd_en     = pop && (op.cmd == CMD_QUERY);
    assign res_valid = res_valid_reg;
    assign hit       = &rd_reg;
    assign clearing  = clear_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clr_idx_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == offset_t'(SECTION_LENGTH - 1))
                begin
                    clear_reg <= 1'b0;
                end
            end
            if (rd_en)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    for (genvar b = 0; b < NUM_HASHES; b++)
    begin : g_bank
        logic    mem [SECTION_LENGTH];
        offset_t waddr;

        assign waddr = clear_reg ? clr_idx_reg : op.offs[b];

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[waddr] <= !clear_reg;
            end
            if (rd_en)
            begin
                rd_reg[b] <= mem[op.offs[b]];
            end
        end
    end

endmodule

// ===== rtl/partitioned_bloom_filter_top.sv =====
`timescale 1ns / 1ps

// Partitioned Bloom filter over 32-bit keys with five sections of 16384 bits.
// The req channel carries one beat per command: command 0 inserts the key,
// command 1 queries it. Inserts produce no beat on the rsp channel; every
// query produces exactly one rsp beat whose hit bit is set when all five
// selected bits are set. Results leave in command order.
// One beat can be accepted every cycle while req.ready is high. A query's
// result passes through five MurmurHash3 pipeline registers, the first
// loaded at the accepting edge, then the command queue and the section
// read registers before rsp.valid rises.
// After reset the sections are swept to zero one address per cycle, all
// sections in parallel; req.ready stays low during the sweep.
// When the rsp receiver stalls, the held result waits in the read registers,
// later commands collect in an eight-entry queue, and req.ready drops once
// the queue plus the hash pipeline would overflow.
module partitioned_bloom_filter_top (
    input logic        clk,
    input logic        rst_n,
    pbf_in_if.sink     req,
    pbf_out_if.source  rsp
);
    import pbf_pkg::*;

    logic               accept;
    logic               push;
    pbf_op_t            front_op;
    logic [STAGE_W-1:0] inflight;
    pbf_op_t            queue_op;
    logic               queue_nonempty;
    logic [FIFO_AW:0]   queue_count;
    logic               pop;
    logic               clearing;
    logic [FIFO_AW+1:0] used;

    assign used      = (FIFO_AW+2)'(queue_count) + (FIFO_AW+2)'(inflight);
    assign req.ready = !clearing && (used < (FIFO_AW+2)'(FIFO_DEPTH));
    assign accept    = req.valid && req.ready;

    pbf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .command  (req.command),
        .key      (req.key),
        .push     (push),
        .op       (front_op),
        .inflight (inflight)
    );

    pbf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (front_op),
        .pop       (pop),
        .rdata     (queue_op),
        .not_empty (queue_nonempty),
        .count     (queue_count)
    );

    pbf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (queue_nonempty),
        .op        (queue_op),
        .pop       (pop),
        .res_valid (rsp.valid),
        .hit       (rsp.hit),
        .res_ready (rsp.ready),
        .clearing  (clearing)
    );

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !accept)
        else $error("command accepted during clear sweep");

    a_queue_not_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (queue_count < (FIFO_AW+1)'(FIFO_DEPTH)))
        else $error("command queue overrun");

    a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> queue_nonempty)
        else $error("pop from empty command queue");
`endif

endmodule
